>>> rtl/bpe_pkg.sv
`default_nettype none

package bpe_pkg;

   // fixed field widths
   localparam int MAX_POINTS   = 16;
   localparam int SAMPLE_BITS  = 16;
   localparam int TIME_W       = 48;
   localparam int LEVEL_W      = 16;
   localparam int STEP_W       = 32;
   localparam int COUNT_REG_W  = 5;
   localparam int INDEX_W      = 4;
   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = 32;

   // derived widths
   localparam int SLOT_W   = $clog2(MAX_POINTS);
   localparam int CNT_W    = $clog2(MAX_POINTS + 1);
   localparam int ENTRY_W  = TIME_W + LEVEL_W;
   localparam int QUO_W    = 17;
   localparam int LOOP_W   = $clog2(QUO_W);
   localparam int REM_W    = TIME_W + 1;
   localparam int MUL_W    = ((SAMPLE_BITS > QUO_W) ? SAMPLE_BITS : QUO_W) + 1;
   localparam int PROD_W   = 2 * MUL_W;
   localparam int GAIN_LSB = 16;
   localparam int PROD_SHIFT = 15;
   localparam int PC_W     = 5;

   localparam logic [LEVEL_W-1:0] UNITY = LEVEL_W'(32768);
   localparam logic [QUO_W-1:0]   QUO_ONE = QUO_W'(65536);
   localparam logic [COUNT_REG_W-1:0] POINT_COUNT_RESET = COUNT_REG_W'(2);
   localparam logic [STEP_W-1:0]  TIME_STEP_RESET = STEP_W'(89478);
   localparam logic signed [PROD_W-1:0] GAIN_ROUND = PROD_W'(32768);
   localparam logic signed [PROD_W-1:0] PROD_ROUND = PROD_W'(16384);
   localparam logic signed [PROD_W-1:0] SAMPLE_MAX =
      {{(PROD_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [PROD_W-1:0] SAMPLE_MIN =
      {{(PROD_W-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

   // opcodes of the input transaction
   localparam logic OPC_LOAD   = 1'b0;
   localparam logic OPC_SAMPLE = 1'b1;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_POINT_COUNT = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_TIME_STEP   = CSR_INDEX_W'(1);

   typedef enum logic [3:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_LD_LEFT,
      OP_LD_RIGHT,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_MUL_L,
      OP_MUL_R,
      OP_ADVANCE,
      OP_INC_SLOT,
      OP_LD_HELD,
      OP_USE_HELD,
      OP_MUL_S,
      OP_OUT_WR
   } op_type;

   typedef enum logic [1:0] {
      ADDR_LEFT,
      ADDR_RIGHT,
      ADDR_LAST
   } addr_sel_type;

   typedef enum logic [3:0] {
      C_ALWAYS,
      C_SAMPLE,
      C_FIN,
      C_SPAN_GONE,
      C_ZERO_W,
      C_LOOP,
      C_NOT_PASSED,
      C_SPAN_LEFT,
      C_RSP_FREE
   } cond_type;

   typedef struct packed {
      op_type            op;
      addr_sel_type      addr_sel;
      cond_type          cond;
      logic              hold;
      logic [PC_W-1:0]   target;
   } ctrl_type;

   typedef struct packed {
      logic sample_acc;
      logic finished;
      logic span_gone;
      logic zero_width;
      logic loop_more;
      logic not_passed;
      logic span_left;
      logic rsp_free;
   } status_type;

   // program step addresses
   localparam logic [PC_W-1:0] ST_IDLE  = PC_W'(0);
   localparam logic [PC_W-1:0] ST_CHK   = PC_W'(1);
   localparam logic [PC_W-1:0] ST_SPAN  = PC_W'(2);
   localparam logic [PC_W-1:0] ST_RDL   = PC_W'(3);
   localparam logic [PC_W-1:0] ST_RDR   = PC_W'(4);
   localparam logic [PC_W-1:0] ST_INIT  = PC_W'(5);
   localparam logic [PC_W-1:0] ST_DIV   = PC_W'(6);
   localparam logic [PC_W-1:0] ST_MULL  = PC_W'(7);
   localparam logic [PC_W-1:0] ST_MULR  = PC_W'(8);
   localparam logic [PC_W-1:0] ST_ADV   = PC_W'(9);
   localparam logic [PC_W-1:0] ST_PASS  = PC_W'(10);
   localparam logic [PC_W-1:0] ST_INC   = PC_W'(11);
   localparam logic [PC_W-1:0] ST_LEFT  = PC_W'(12);
   localparam logic [PC_W-1:0] ST_LFIN  = PC_W'(13);
   localparam logic [PC_W-1:0] ST_EFIN  = PC_W'(14);
   localparam logic [PC_W-1:0] ST_EHLD  = PC_W'(15);
   localparam logic [PC_W-1:0] ST_HELD  = PC_W'(16);
   localparam logic [PC_W-1:0] ST_OMUL  = PC_W'(17);
   localparam logic [PC_W-1:0] ST_OWR   = PC_W'(18);

   // count register clamped to the table size
   function automatic logic [CNT_W-1:0] used_count(input logic [COUNT_REG_W-1:0] pc);
      int v;
      v = int'(pc);
      if (v < 2) v = 2;
      if (v > MAX_POINTS) v = MAX_POINTS;
      return CNT_W'(v);
   endfunction

   // control store
   function automatic ctrl_type ucode_rom(input logic [PC_W-1:0] pc);
      ctrl_type w;
      unique case (pc)
         ST_IDLE: w = '{OP_ACCEPT,   ADDR_LEFT,  C_SAMPLE,     1'b1, ST_CHK};
         ST_CHK:  w = '{OP_NONE,     ADDR_LEFT,  C_FIN,        1'b0, ST_HELD};
         ST_SPAN: w = '{OP_NONE,     ADDR_LEFT,  C_SPAN_GONE,  1'b0, ST_EFIN};
         ST_RDL:  w = '{OP_LD_LEFT,  ADDR_RIGHT, C_ALWAYS,     1'b0, ST_RDR};
         ST_RDR:  w = '{OP_LD_RIGHT, ADDR_LEFT,  C_ALWAYS,     1'b0, ST_INIT};
         ST_INIT: w = '{OP_DIV_INIT, ADDR_LEFT,  C_ZERO_W,     1'b0, ST_ADV};
         ST_DIV:  w = '{OP_DIV_STEP, ADDR_LEFT,  C_LOOP,       1'b0, ST_DIV};
         ST_MULL: w = '{OP_MUL_L,    ADDR_LEFT,  C_ALWAYS,     1'b0, ST_MULR};
         ST_MULR: w = '{OP_MUL_R,    ADDR_LEFT,  C_ALWAYS,     1'b0, ST_ADV};
         ST_ADV:  w = '{OP_ADVANCE,  ADDR_LEFT,  C_ALWAYS,     1'b0, ST_PASS};
         ST_PASS: w = '{OP_NONE,     ADDR_LEFT,  C_NOT_PASSED, 1'b0, ST_OMUL};
         ST_INC:  w = '{OP_INC_SLOT, ADDR_LEFT,  C_ALWAYS,     1'b0, ST_LEFT};
         ST_LEFT: w = '{OP_NONE,     ADDR_LAST,  C_SPAN_LEFT,  1'b0, ST_OMUL};
         ST_LFIN: w = '{OP_LD_HELD,  ADDR_LEFT,  C_ALWAYS,     1'b0, ST_OMUL};
         ST_EFIN: w = '{OP_NONE,     ADDR_LAST,  C_ALWAYS,     1'b0, ST_EHLD};
         ST_EHLD: w = '{OP_LD_HELD,  ADDR_LEFT,  C_ALWAYS,     1'b0, ST_HELD};
         ST_HELD: w = '{OP_USE_HELD, ADDR_LEFT,  C_ALWAYS,     1'b0, ST_OMUL};
         ST_OMUL: w = '{OP_MUL_S,    ADDR_LEFT,  C_ALWAYS,     1'b0, ST_OWR};
         ST_OWR:  w = '{OP_OUT_WR,   ADDR_LEFT,  C_RSP_FREE,   1'b1, ST_IDLE};
         default: w = '{OP_NONE,     ADDR_LEFT,  C_ALWAYS,     1'b0, ST_IDLE};
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

>>> rtl/bpe_ram.sv
`default_nettype none

module bpe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/bpe_sequencer.sv
`default_nettype none

module bpe_sequencer (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire bpe_pkg::status_type   status,
   output bpe_pkg::ctrl_type          ctrl
);
   import bpe_pkg::*;

   logic [PC_W-1:0] pc_ff;
   logic [PC_W-1:0] pc_in;
   logic            taken;

   assign ctrl = ucode_rom(pc_ff);

   // branch condition select
   always_comb begin
      case (ctrl.cond)
         C_ALWAYS:     taken = 1'b1;
         C_SAMPLE:     taken = status.sample_acc;
         C_FIN:        taken = status.finished;
         C_SPAN_GONE:  taken = status.span_gone;
         C_ZERO_W:     taken = status.zero_width;
         C_LOOP:       taken = status.loop_more;
         C_NOT_PASSED: taken = status.not_passed;
         C_SPAN_LEFT:  taken = status.span_left;
         C_RSP_FREE:   taken = status.rsp_free;
         default:      taken = 1'b1;
      endcase
   end

   always_comb begin
      if (taken) begin
         pc_in = ctrl.target;
      end else if (ctrl.hold) begin
         pc_in = pc_ff;
      end else begin
         pc_in = pc_ff + PC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= ST_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/bpe_datapath.sv
`default_nettype none

module bpe_datapath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_wr_en,
   input  wire logic [bpe_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [bpe_pkg::CSR_DATA_W-1:0]      csr_wr_data,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic                                req_opcode,
   input  wire logic [bpe_pkg::INDEX_W-1:0]         req_point_index,
   input  wire logic [bpe_pkg::TIME_W-1:0]          req_point_time,
   input  wire logic [bpe_pkg::LEVEL_W-1:0]         req_point_level,
   input  wire logic signed [bpe_pkg::SAMPLE_BITS-1:0] req_sample_in,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic signed [bpe_pkg::SAMPLE_BITS-1:0]   rsp_sample_out,
   output logic [bpe_pkg::LEVEL_W-1:0]              rsp_gain_used,
   output logic                                     rsp_envelope_done,
   input  wire bpe_pkg::ctrl_type                   ctrl,
   output bpe_pkg::status_type                      status
);
   import bpe_pkg::*;

   // configuration and playback state
   logic [COUNT_REG_W-1:0] point_count_ff;
   logic [STEP_W-1:0]      time_step_ff;
   logic [TIME_W-1:0]      pos_ff;
   logic [SLOT_W-1:0]      slot_ff;
   logic                   fin_ff;
   logic [LEVEL_W-1:0]     held_ff;
   logic                   rsp_valid_ff;

   // working registers
   logic [TIME_W-1:0]      tl_ff;
   logic [TIME_W-1:0]      tr_ff;
   logic [LEVEL_W-1:0]     lvl_l_ff;
   logic [LEVEL_W-1:0]     lvl_r_ff;
   logic [TIME_W-1:0]      width_ff;
   logic [REM_W-1:0]       rem_ff;
   logic [QUO_W-1:0]       quo_ff;
   logic [LOOP_W-1:0]      loop_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic [LEVEL_W-1:0]     gain_ff;
   logic signed [SAMPLE_BITS-1:0] sample_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_ff;
   logic [LEVEL_W-1:0]     rsp_gain_ff;
   logic                   rsp_done_ff;

   logic                   accept;
   logic                   load_acc;
   logic                   rsp_free;
   logic [CNT_W-1:0]       count;
   logic [SLOT_W-1:0]      last_slot;
   logic [CNT_W-1:0]       slot_next_ext;

   logic                   ram_wr_en;
   logic [SLOT_W-1:0]      ram_rd_addr;
   logic [ENTRY_W-1:0]     ram_rd_data;
   logic [LEVEL_W-1:0]     lvl_sat;
   logic [TIME_W-1:0]      rd_time;
   logic [LEVEL_W-1:0]     rd_level;

   logic [TIME_W-1:0]      off_raw;
   logic [TIME_W-1:0]      width_now;
   logic [TIME_W-1:0]      off_clamp;
   logic                   rem_ge;
   logic [REM_W-1:0]       rem_sub;
   logic [REM_W-1:0]       rem_next;

   logic [MUL_W-1:0]       mul_a;
   logic [MUL_W-1:0]       mul_b;
   logic signed [PROD_W-1:0] mul_p;
   logic signed [PROD_W-1:0] gain_acc;
   logic signed [PROD_W-1:0] rounded;
   logic signed [PROD_W-1:0] scaled;
   logic signed [SAMPLE_BITS-1:0] sample_sat;

   logic [TIME_W:0]        pos_sum;
   logic [TIME_W-1:0]      pos_adv;

   assign req_ready = (ctrl.op == OP_ACCEPT);
   assign accept    = req_valid && req_ready;
   assign load_acc  = accept && (req_opcode == OPC_LOAD);
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   assign count         = used_count(point_count_ff);
   assign last_slot     = SLOT_W'(count - CNT_W'(1));
   assign slot_next_ext = CNT_W'(slot_ff) + CNT_W'(1);

   // breakpoint table
   assign ram_wr_en = load_acc && (int'(req_point_index) < MAX_POINTS);
   assign lvl_sat   = (req_point_level > UNITY) ? UNITY : req_point_level;

   always_comb begin
      unique case (ctrl.addr_sel)
         ADDR_LEFT:  ram_rd_addr = slot_ff;
         ADDR_RIGHT: ram_rd_addr = slot_ff + SLOT_W'(1);
         ADDR_LAST:  ram_rd_addr = last_slot;
         default:    ram_rd_addr = slot_ff;
      endcase
   end

   bpe_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_POINTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (SLOT_W'(req_point_index)),
      .wr_data ({req_point_time, lvl_sat}),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_time  = ram_rd_data[ENTRY_W-1:LEVEL_W];
   assign rd_level = ram_rd_data[LEVEL_W-1:0];

   // offset into the span, clamped to its width
   assign off_raw   = (pos_ff > tl_ff) ? (pos_ff - tl_ff) : '0;
   assign width_now = tr_ff - tl_ff;
   assign off_clamp = (off_raw > width_now) ? width_now : off_raw;

   // one restoring divide step
   assign rem_ge   = rem_ff >= {1'b0, width_ff};
   assign rem_sub  = rem_ge ? (rem_ff - {1'b0, width_ff}) : rem_ff;
   assign rem_next = {rem_sub[REM_W-2:0], 1'b0};

   // shared multiplier
   always_comb begin
      case (ctrl.op)
         OP_MUL_L: begin
            mul_a = MUL_W'(lvl_l_ff);
            mul_b = MUL_W'(QUO_ONE - quo_ff);
         end
         OP_MUL_R: begin
            mul_a = MUL_W'(lvl_r_ff);
            mul_b = MUL_W'(quo_ff);
         end
         default: begin
            mul_a = MUL_W'(sample_ff);
            mul_b = MUL_W'(gain_ff);
         end
      endcase
   end

   assign mul_p    = $signed(mul_a) * $signed(mul_b);
   assign gain_acc = prod_ff + mul_p + GAIN_ROUND;

   // output rounding and saturation
   assign rounded = prod_ff + PROD_ROUND;
   assign scaled  = rounded >>> PROD_SHIFT;
   always_comb begin
      if (scaled > SAMPLE_MAX) begin
         sample_sat = SAMPLE_MAX[SAMPLE_BITS-1:0];
      end else if (scaled < SAMPLE_MIN) begin
         sample_sat = SAMPLE_MIN[SAMPLE_BITS-1:0];
      end else begin
         sample_sat = scaled[SAMPLE_BITS-1:0];
      end
   end

   // saturating position advance
   assign pos_sum = {1'b0, pos_ff} + (TIME_W+1)'(time_step_ff);
   assign pos_adv = pos_sum[TIME_W] ? '1 : pos_sum[TIME_W-1:0];

   always_comb begin
      status.sample_acc = accept && (req_opcode == OPC_SAMPLE);
      status.finished   = fin_ff;
      status.span_gone  = slot_next_ext >= count;
      status.span_left  = slot_next_ext < count;
      status.zero_width = tr_ff <= tl_ff;
      status.loop_more  = loop_ff != '0;
      status.not_passed = pos_ff <= tr_ff;
      status.rsp_free   = rsp_free;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= POINT_COUNT_RESET;
         time_step_ff   <= TIME_STEP_RESET;
         pos_ff         <= '0;
         slot_ff        <= '0;
         fin_ff         <= 1'b0;
         held_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_POINT_COUNT: point_count_ff <= csr_wr_data[COUNT_REG_W-1:0];
               CSR_TIME_STEP:   time_step_ff   <= csr_wr_data[STEP_W-1:0];
               default: ;
            endcase
         end
         if (load_acc) begin
            pos_ff  <= '0;
            slot_ff <= '0;
            fin_ff  <= 1'b0;
            held_ff <= '0;
         end
         case (ctrl.op)
            OP_ADVANCE:  pos_ff  <= pos_adv;
            OP_INC_SLOT: slot_ff <= slot_ff + SLOT_W'(1);
            OP_LD_HELD: begin
               held_ff <= rd_level;
               fin_ff  <= 1'b1;
            end
            default: ;
         endcase
         if (ctrl.op == OP_OUT_WR && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (status.sample_acc) begin
         sample_ff <= req_sample_in;
      end
      case (ctrl.op)
         OP_LD_LEFT: begin
            tl_ff    <= rd_time;
            lvl_l_ff <= rd_level;
         end
         OP_LD_RIGHT: begin
            tr_ff    <= rd_time;
            lvl_r_ff <= rd_level;
         end
         OP_DIV_INIT: begin
            gain_ff  <= lvl_r_ff;
            width_ff <= width_now;
            rem_ff   <= {1'b0, off_clamp};
            quo_ff   <= '0;
            loop_ff  <= LOOP_W'(QUO_W - 1);
         end
         OP_DIV_STEP: begin
            rem_ff  <= rem_next;
            quo_ff  <= {quo_ff[QUO_W-2:0], rem_ge};
            loop_ff <= loop_ff - LOOP_W'(1);
         end
         OP_MUL_L:    prod_ff <= mul_p;
         OP_MUL_R:    gain_ff <= gain_acc[GAIN_LSB+LEVEL_W-1:GAIN_LSB];
         OP_USE_HELD: gain_ff <= held_ff;
         OP_MUL_S:    prod_ff <= mul_p;
         OP_OUT_WR: begin
            if (rsp_free) begin
               rsp_sample_ff <= sample_sat;
               rsp_gain_ff   <= gain_ff;
               rsp_done_ff   <= fin_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_sample_out    = rsp_sample_ff;
   assign rsp_gain_used     = rsp_gain_ff;
   assign rsp_envelope_done = rsp_done_ff;

endmodule

`default_nettype wire

>>> rtl/breakpoint_envelope_gain.sv
// load transaction: taken while idle, writes the table and rewinds, no response
// sample response: a span runs the serial divider, a zero-width span skips it, a span
//   change adds the slot step, and once finished the held gain is used directly
// a new sample is taken only once the last one is through the microcode path;
//   a response still waiting holds the last step until it is taken
// reset: pc, position, slot, finished, held gain cleared; count 2, step 89478; table kept
`default_nettype none

module breakpoint_envelope_gain (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // configuration writes
   input  wire logic                                csr_wr_en,
   input  wire logic [bpe_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [bpe_pkg::CSR_DATA_W-1:0]      csr_wr_data,
   // request channel
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic                                req_opcode,
   input  wire logic [bpe_pkg::INDEX_W-1:0]         req_point_index,
   input  wire logic [bpe_pkg::TIME_W-1:0]          req_point_time,
   input  wire logic [bpe_pkg::LEVEL_W-1:0]         req_point_level,
   input  wire logic signed [bpe_pkg::SAMPLE_BITS-1:0] req_sample_in,
   // response channel
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic signed [bpe_pkg::SAMPLE_BITS-1:0]   rsp_sample_out,
   output logic [bpe_pkg::LEVEL_W-1:0]              rsp_gain_used,
   output logic                                     rsp_envelope_done
);
   import bpe_pkg::*;

   // control word from the microcode store, flags back from the datapath
   ctrl_type   ctrl;
   status_type status;

   // program counter, control store and branch logic
   bpe_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   // table memory, serial divider, shared multiplier and the response register;
   // the response register lets the next transaction in while one still waits
   bpe_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_point_index   (req_point_index),
      .req_point_time    (req_point_time),
      .req_point_level   (req_point_level),
      .req_sample_in     (req_sample_in),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_sample_out    (rsp_sample_out),
      .rsp_gain_used     (rsp_gain_used),
      .rsp_envelope_done (rsp_envelope_done),
      .ctrl              (ctrl),
      .status            (status)
   );

endmodule

`default_nettype wire

>>> rtl/bpe_checker.sv
`default_nettype none

module bpe_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_valid,
   input wire logic                                req_ready,
   input wire logic                                req_opcode,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_ready,
   input wire logic signed [bpe_pkg::SAMPLE_BITS-1:0] rsp_sample_out,
   input wire logic [bpe_pkg::LEVEL_W-1:0]         rsp_gain_used,
   input wire logic                                rsp_envelope_done
);
   import bpe_pkg::*;

   // stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample_out)
         && $stable(rsp_gain_used) && $stable(rsp_envelope_done))
      else $error("response changed while stalled");

   // gain never exceeds unity
   a_gain_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_gain_used <= UNITY)
      else $error("gain above unity");

   // a load transaction never produces a response
   a_load_quiet: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_opcode == OPC_LOAD && !rsp_valid |=> !rsp_valid)
      else $error("response after load");

   // a sample transaction occupies the block
   a_sample_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_opcode == OPC_SAMPLE |=> !req_ready)
      else $error("ready right after sample");

   // nothing pending out of reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind breakpoint_envelope_gain bpe_checker u_bpe_checker (.*);

`default_nettype wire
